/* hdl/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, masked during reset.
`define ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication that also checks reset behavior.
`define ASSERT_NXT_RST(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

/* hdl/osc_pkg.sv */
// Package: types and constants of the obstacle sector classifier.
`default_nettype none
package osc_pkg;

   localparam int DIST_W  = 16;
   localparam int GAPW_W  = 6;
   localparam int GC_W    = 5;
   localparam int WS_W    = 6;
   localparam int WL_W    = 6;
   localparam int TOTAL_W = 6;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIST_W-1:0] WARN_DIST_RST  = 16'd1500;
   localparam logic [DIST_W-1:0] AVOID_DIST_RST = 16'd1000;
   localparam logic [DIST_W-1:0] STOP_DIST_RST  = 16'd300;
   localparam logic [GAPW_W-1:0] MIN_GAP_RST    = 6'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WARN_DIST  = 2'd0,
      CSR_AVOID_DIST = 2'd1,
      CSR_STOP_DIST  = 2'd2,
      CSR_MIN_GAP    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_WARN  = 2'd1,
      MODE_AVOID = 2'd2,
      MODE_STOP  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SCAN,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic              kind;
      logic              blocked;
      logic [DIST_W-1:0] distance_mm;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [1:0]      mode;
      logic [GC_W-1:0] gap_count;
      logic [WS_W-1:0] widest_start;
      logic [WL_W-1:0] widest_length;
   } rsp_type;

   typedef struct packed {
      logic [DIST_W-1:0] warning_distance;
      logic [DIST_W-1:0] avoid_distance;
      logic [DIST_W-1:0] stop_distance;
      logic [GAPW_W-1:0] min_gap_width;
   } cfg_type;

   typedef struct packed {
      logic [GC_W-1:0] gap_count;
      logic [WS_W-1:0] widest_start;
      logic [WL_W-1:0] widest_length;
   } gap_result_type;

endpackage
`default_nettype wire

/* hdl/obstacle_sector_classifier.sv */
// Top level: handshake, configuration registers, sequencer and output register.
`default_nettype none
// Takes one sector reading per beat. A reading without last is captured while idle and
// then updates the state before the next is accepted. A reading with last also runs
// the gap scanner, which walks the stored map one sector per cycle over SECTORS+1
// steps; the result then goes from the hold state into the output register and the
// block returns to idle for the next reading. A finished result waits in the output
// register while the next reading is taken; if an earlier result is still waiting
// there at scan end, the block holds off the input until that result is taken. The user
// writes thresholds through the csr_ port only while the block is idle; it is not enforced.
module obstacle_sector_classifier #(
   parameter int SECTORS = 36
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire osc_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output osc_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_we,
   input  wire logic [osc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [osc_pkg::DIST_W-1:0]    csr_wdata
);
   import osc_pkg::*;

   state_type       state_ff, state_in;
   cfg_type         cfg_ff, cfg_in;
   req_type         item_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff;
   logic            upd_en, scan_start, scan_done, load_rsp;
   logic [SECTORS-1:0] blocked_map;
   mode_type        result_mode;
   gap_result_type  gap_result;

   osc_classify #(.SECTORS(SECTORS)) u_classify (
      .clock       (clock),
      .reset       (reset),
      .upd_en      (upd_en),
      .item        (item_ff),
      .cfg         (cfg_ff),
      .blocked_map (blocked_map),
      .result_mode (result_mode)
   );

   osc_gap_scan #(.SECTORS(SECTORS)) u_gap_scan (
      .clock         (clock),
      .reset         (reset),
      .start         (scan_start),
      .blocked_map   (blocked_map),
      .min_gap_width (cfg_ff.min_gap_width),
      .done          (scan_done),
      .result        (gap_result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_WARN_DIST:  cfg_in.warning_distance = csr_wdata;
            CSR_AVOID_DIST: cfg_in.avoid_distance   = csr_wdata;
            CSR_STOP_DIST:  cfg_in.stop_distance    = csr_wdata;
            CSR_MIN_GAP:    cfg_in.min_gap_width    = csr_wdata[GAPW_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_UPDATE;
         ST_UPDATE: state_in = item_ff.last ? ST_SCAN : ST_IDLE;
         ST_SCAN:   if (scan_done) state_in = ST_HOLD;
         ST_HOLD:   if (load_rsp) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      upd_en     = 1'b0;
      scan_start = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_UPDATE: begin
            upd_en     = 1'b1;
            scan_start = item_ff.last;
         end
         ST_SCAN:   ;
         ST_HOLD:   load_rsp = !rsp_valid_ff || rsp_ready;
         default:   ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                <= ST_IDLE;
         rsp_valid_ff            <= 1'b0;
         cfg_ff.warning_distance <= WARN_DIST_RST;
         cfg_ff.avoid_distance   <= AVOID_DIST_RST;
         cfg_ff.stop_distance    <= STOP_DIST_RST;
         cfg_ff.min_gap_width    <= MIN_GAP_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
      if (req_valid && req_ready) item_ff <= req_data;
      if (load_rsp) begin
         rsp_ff.mode          <= result_mode;
         rsp_ff.gap_count     <= gap_result.gap_count;
         rsp_ff.widest_start  <= gap_result.widest_start;
         rsp_ff.widest_length <= gap_result.widest_length;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

/* hdl/osc_classify.sv */
// Per-reading threshold classification, blocked count and sector map.
`default_nettype none
module osc_classify #(
   parameter int SECTORS = 36
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   upd_en,
   input  wire osc_pkg::req_type       item,
   input  wire osc_pkg::cfg_type       cfg,
   output logic [SECTORS-1:0]          blocked_map,
   output osc_pkg::mode_type           result_mode
);
   import osc_pkg::*;

   localparam int HALF   = SECTORS / 2;
   localparam int SLOT_W = $clog2(HALF + 1);
   localparam int SEC_W  = $clog2(SECTORS);

   logic [SECTORS-1:0] map_ff, map_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   mode_type           mode_ff, mode_in;
   mode_type           res_ff, res_in;
   logic               stopped_ff, stopped_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SEC_W-1:0]   sector;
   logic               in_range;
   logic               lt_warn, lt_avoid, lt_stop;

   assign in_range = 32'(slot_ff) < HALF;
   assign sector   = SEC_W'((32'(slot_ff) << 1) | 32'(item.kind));
   assign lt_warn  = item.distance_mm < cfg.warning_distance;
   assign lt_avoid = item.distance_mm < cfg.avoid_distance;
   assign lt_stop  = item.distance_mm < cfg.stop_distance;

   always_comb begin
      map_in     = map_ff;
      total_in   = total_ff;
      mode_in    = mode_ff;
      res_in     = res_ff;
      stopped_in = stopped_ff;
      slot_in    = slot_ff;
      if (upd_en) begin
         if (in_range) begin
            map_in[sector] = item.blocked;
            if (!item.kind) begin
               if (item.blocked) begin
                  if (total_ff != '1) total_in = total_ff + 1'b1;
                  if (mode_in < MODE_WARN) mode_in = MODE_WARN;
               end
               if (lt_warn && mode_in < MODE_WARN) mode_in = MODE_WARN;
               if (lt_stop) mode_in = MODE_STOP;
            end else if (!stopped_ff) begin
               if (item.blocked && total_ff != '1) total_in = total_ff + 1'b1;
               if (lt_warn && mode_in < MODE_WARN) mode_in = MODE_WARN;
               if (lt_avoid && mode_in < MODE_AVOID) mode_in = MODE_AVOID;
               if (lt_stop) begin
                  mode_in    = MODE_STOP;
                  stopped_in = 1'b1;
               end
            end
            slot_in = slot_ff + 1'b1;
         end
         if (item.last) begin
            if (item.kind) begin
               if (total_in != '0) begin
                  total_in = '0;
                  if (mode_in != MODE_STOP) mode_in = MODE_AVOID;
               end else begin
                  mode_in = MODE_NONE;
               end
            end
            res_in     = mode_in;
            mode_in    = MODE_NONE;
            stopped_in = 1'b0;
            slot_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff     <= '0;
         total_ff   <= '0;
         mode_ff    <= MODE_NONE;
         res_ff     <= MODE_NONE;
         stopped_ff <= 1'b0;
         slot_ff    <= '0;
      end else begin
         map_ff     <= map_in;
         total_ff   <= total_in;
         mode_ff    <= mode_in;
         res_ff     <= res_in;
         stopped_ff <= stopped_in;
         slot_ff    <= slot_in;
      end
   end

   assign blocked_map = map_ff;
   assign result_mode = res_ff;

endmodule
`default_nettype wire

/* hdl/osc_gap_scan.sv */
// Iterative gap scanner: walks the sector map one sector per cycle.
`default_nettype none
module osc_gap_scan #(
   parameter int SECTORS = 36
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [SECTORS-1:0]            blocked_map,
   input  wire logic [osc_pkg::GAPW_W-1:0]    min_gap_width,
   output logic                               done,
   output osc_pkg::gap_result_type            result
);
   import osc_pkg::*;

   localparam int SEC_W = $clog2(SECTORS);
   localparam int CNT_W = $clog2(SECTORS + 1);

   logic               active_ff, active_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   run_ff, run_in;
   logic [GC_W-1:0]    n_ff, n_in;
   logic [CNT_W-1:0]   best_len_ff, best_len_in;
   logic [SEC_W-1:0]   best_start_ff, best_start_in;
   logic [GAPW_W-1:0]  minw;
   logic               at_end, free_here, run_long;

   assign minw      = (min_gap_width == '0) ? GAPW_W'(1) : min_gap_width;
   assign at_end    = idx_ff == CNT_W'(SECTORS);
   assign free_here = !at_end && !blocked_map[idx_ff[SEC_W-1:0]];
   assign run_long  = 32'(run_ff) >= 32'(minw);

   always_comb begin
      active_in     = active_ff;
      done_in       = 1'b0;
      idx_in        = idx_ff;
      run_in        = run_ff;
      n_in          = n_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      if (start) begin
         active_in     = 1'b1;
         idx_in        = '0;
         run_in        = '0;
         n_in          = '0;
         best_len_in   = '0;
         best_start_in = '0;
      end else if (active_ff) begin
         if (free_here) begin
            run_in = run_ff + 1'b1;
         end else begin
            if (run_long) begin
               if (n_ff != '1) n_in = n_ff + 1'b1;
               if (run_ff > best_len_ff) begin
                  best_len_in   = run_ff;
                  best_start_in = SEC_W'(idx_ff - run_ff);
               end
            end
            run_in = '0;
         end
         idx_in = idx_ff + 1'b1;
         if (at_end) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      idx_ff        <= idx_in;
      run_ff        <= run_in;
      n_ff          <= n_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
   end

   assign done                 = done_ff;
   assign result.gap_count     = n_ff;
   assign result.widest_start  = WS_W'(best_start_ff);
   assign result.widest_length = (32'(best_len_ff) > 63) ? WL_W'(63) : WL_W'(best_len_ff);

endmodule
`default_nettype wire

/* hdl/osc_checker.sv */
// Port-level checker for the obstacle sector classifier, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module osc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire osc_pkg::rsp_type  rsp_data
);

   // stalled result beat holds
   `ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   // one reading at a time: busy after a beat is taken
   `ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready)
   // no result straight out of reset
   `ASSERT_NXT_RST(a_rst_empty, reset, !rsp_valid)
   // a widest gap implies at least one counted gap
   `ASSERT_IMP(a_gap_consistent, rsp_valid && rsp_data.widest_length != '0,
               rsp_data.gap_count != '0)
   // no gap means start reads zero
   `ASSERT_IMP(a_no_gap_start, rsp_valid && rsp_data.widest_length == '0,
               rsp_data.widest_start == '0)

endmodule

bind obstacle_sector_classifier osc_checker u_osc_checker (.*);
`default_nettype wire
